// ----- rtl/core/cfc_pkg.sv -----
// cfc_pkg: shared types, status codes and the byte-wide crc-32 step
// for the crc-32 frame checker; no dependencies
package cfc_pkg;

  localparam logic [31:0] CRC_POLY    = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT    = 32'hFFFFFFFF;
  localparam int          MIN_FRAME   = 5;
  localparam int          TRAILER_LEN = 4;
  localparam int          SERIAL_LEN  = 4;
  localparam int          QUEUE_DEPTH = 4;
  localparam int          QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_SHORT     = 3'd1;
  localparam logic [2:0] ST_BAD_TYPE  = 3'd2;
  localparam logic [2:0] ST_CRC_ERR   = 3'd3;
  localparam logic [2:0] ST_NO_SERIAL = 3'd4;

  localparam logic KIND_BODY   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic CFG_TYPE_LIMIT  = 1'b0;
  localparam logic CFG_SERIAL_MODE = 1'b1;

  typedef struct packed {
    logic        has_body;
    logic [7:0]  body_byte;
    logic [15:0] body_len;
    logic        has_status;
    logic [2:0]  status;
    logic [7:0]  frame_type;
    logic [15:0] stat_len;
    logic [31:0] crc;
    logic [31:0] serial;
  } cfc_cmd_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] acc_in, input logic [7:0] b);
    logic [31:0] acc;
    acc = acc_in ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      acc = (acc >> 1) ^ (acc[0] ? CRC_POLY : 32'd0);
    end
    return acc;
  endfunction

endpackage

// ----- rtl/core/cfc_front.sv -----
// cfc_front: takes frame bytes, runs the trailer window, crc and counters,
// and turns each byte into at most one command for the back end; uses cfc_pkg
module cfc_front #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,
  input  logic [7:0]        data_byte,
  input  logic              last,
  input  logic [8:0]        type_limit,
  input  logic              serial_mode,
  output logic              push,
  output cfc_pkg::cfc_cmd_t push_cmd
);

  localparam int LW = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  logic [7:0]             win_r [4];
  logic [7:0]             win_nxt [4];
  logic [31:0]            crc_r, crc_nxt;
  logic [COUNT_WIDTH-1:0] count_r, count_nxt;
  logic [7:0]             type_r, type_nxt;
  logic [31:0]            serial_r, serial_nxt;

  logic [COUNT_WIDTH-1:0] pos, done_full, len_body, stat_full;
  logic [LW-1:0]          done_ext, stat_ext;
  logic [1:0]             ser_idx;
  logic [31:0]            crc_fin, given;

  always_comb begin
    push_cmd = '0;
    push = 1'b0;
    type_nxt = (count_r == '0) ? data_byte : type_r;
    crc_nxt = crc_r;
    serial_nxt = serial_r;
    pos = count_r - COUNT_WIDTH'(cfc_pkg::TRAILER_LEN);
    ser_idx = 2'(pos - COUNT_WIDTH'(1));
    done_full = serial_mode ? pos - COUNT_WIDTH'(cfc_pkg::SERIAL_LEN) : pos;
    done_ext = LW'(done_full);
    push_cmd.frame_type = type_nxt;
    push_cmd.body_byte = win_r[0];
    push_cmd.body_len = (done_ext > LW'(16'hFFFF)) ? 16'hFFFF : done_ext[15:0];

    if (count_r >= COUNT_WIDTH'(cfc_pkg::TRAILER_LEN)) begin
      crc_nxt = cfc_pkg::crc_byte(crc_r, win_r[0]);
      if (pos >= COUNT_WIDTH'(1)) begin
        if (serial_mode && pos <= COUNT_WIDTH'(cfc_pkg::SERIAL_LEN)) begin
          serial_nxt = serial_r | ({24'd0, win_r[0]} << {ser_idx, 3'b000});
        end else begin
          push_cmd.has_body = 1'b1;
        end
      end
    end

    win_nxt[0] = win_r[1];
    win_nxt[1] = win_r[2];
    win_nxt[2] = win_r[3];
    win_nxt[3] = data_byte;
    count_nxt = (count_r == CNT_MAX) ? count_r : count_r + COUNT_WIDTH'(1);

    crc_fin = ~crc_nxt;
    given = {data_byte, win_r[3], win_r[2], win_r[1]};
    len_body = (count_nxt >= COUNT_WIDTH'(cfc_pkg::MIN_FRAME))
             ? count_nxt - COUNT_WIDTH'(cfc_pkg::MIN_FRAME) : '0;
    if (serial_mode) begin
      stat_full = (len_body > COUNT_WIDTH'(cfc_pkg::SERIAL_LEN))
                ? len_body - COUNT_WIDTH'(cfc_pkg::SERIAL_LEN) : '0;
    end else begin
      stat_full = len_body;
    end
    stat_ext = LW'(stat_full);

    push_cmd.has_status = last;
    push_cmd.stat_len = (stat_ext > LW'(16'hFFFF)) ? 16'hFFFF : stat_ext[15:0];
    push_cmd.crc = (count_nxt >= COUNT_WIDTH'(cfc_pkg::MIN_FRAME)) ? crc_fin : 32'd0;
    push_cmd.serial = serial_mode ? serial_nxt : 32'd0;
    if (count_nxt < COUNT_WIDTH'(cfc_pkg::MIN_FRAME)) begin
      push_cmd.status = cfc_pkg::ST_SHORT;
    end else if ({1'b0, type_nxt} >= type_limit) begin
      push_cmd.status = cfc_pkg::ST_BAD_TYPE;
    end else if (crc_fin != given) begin
      push_cmd.status = cfc_pkg::ST_CRC_ERR;
    end else if (serial_mode && len_body < COUNT_WIDTH'(cfc_pkg::SERIAL_LEN)) begin
      push_cmd.status = cfc_pkg::ST_NO_SERIAL;
    end else begin
      push_cmd.status = cfc_pkg::ST_OK;
    end

    push = take && (push_cmd.has_body || push_cmd.has_status);

    if (last) begin
      crc_nxt = cfc_pkg::CRC_INIT;
      count_nxt = '0;
      type_nxt = 8'd0;
      serial_nxt = 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= cfc_pkg::CRC_INIT;
      count_r <= '0;
      type_r <= 8'd0;
      serial_r <= 32'd0;
    end else if (take) begin
      crc_r <= crc_nxt;
      count_r <= count_nxt;
      type_r <= type_nxt;
      serial_r <= serial_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      win_r <= win_nxt;
    end
  end

endmodule

// ----- rtl/core/cfc_queue.sv -----
// cfc_queue: short command queue between front and back end;
// uses cfc_pkg for the command type
module cfc_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  cfc_pkg::cfc_cmd_t push_cmd,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output cfc_pkg::cfc_cmd_t head_cmd
);

  localparam int PW = cfc_pkg::QPTR_W;

  cfc_pkg::cfc_cmd_t mem_r [cfc_pkg::QUEUE_DEPTH];
  logic [PW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]       fill_r, fill_nxt;

  assign full = (fill_r == (PW+1)'(cfc_pkg::QUEUE_DEPTH));
  assign head_valid = (fill_r != '0);
  assign head_cmd = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + PW'(1) : rd_ptr_r;
    fill_nxt = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + (PW+1)'(1);
    end else if (pop && !push) begin
      fill_nxt = fill_r - (PW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ----- rtl/core/cfc_back.sv -----
// cfc_back: expands queued commands into body and status results and
// holds them in the output register; uses cfc_pkg
module cfc_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head_valid,
  input  cfc_pkg::cfc_cmd_t head_cmd,
  output logic              pop,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [103:0]      out_tdata,
  output logic              out_tuser,
  output logic              out_tlast
);

  logic         valid_r, valid_nxt;
  logic         phase_r, phase_nxt;
  logic         load;
  logic         body_now;
  logic         kind_r;
  logic         eor_r;
  logic [7:0]   body_r;
  logic [2:0]   status_r;
  logic [7:0]   type_r;
  logic [15:0]  len_r;
  logic [31:0]  crc_r;
  logic [31:0]  serial_r;

  assign load = head_valid && (!valid_r || out_tready);
  assign body_now = head_cmd.has_body && !phase_r;
  assign pop = load && !(body_now && head_cmd.has_status);

  always_comb begin
    valid_nxt = valid_r;
    phase_nxt = phase_r;
    if (load) begin
      valid_nxt = 1'b1;
      phase_nxt = body_now && head_cmd.has_status;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      type_r <= head_cmd.frame_type;
      eor_r <= pop;
      if (body_now) begin
        kind_r <= cfc_pkg::KIND_BODY;
        body_r <= head_cmd.body_byte;
        status_r <= cfc_pkg::ST_OK;
        len_r <= head_cmd.body_len;
        crc_r <= 32'd0;
        serial_r <= 32'd0;
      end else begin
        kind_r <= cfc_pkg::KIND_STATUS;
        body_r <= 8'd0;
        status_r <= head_cmd.status;
        len_r <= head_cmd.stat_len;
        crc_r <= head_cmd.crc;
        serial_r <= head_cmd.serial;
      end
    end
  end

  assign out_tvalid = valid_r;
  assign out_tuser = kind_r;
  assign out_tlast = eor_r;
  assign out_tdata = {5'd0, serial_r, crc_r, len_r, type_r, status_r, body_r};

endmodule

// ----- rtl/core/crc32_frame_checker.sv -----
// crc32_frame_checker: top level of the crc-32 trailer frame checker
// depends on cfc_pkg, cfc_front, cfc_queue and cfc_back
//
// frame bytes enter on in_* (tdata = byte, tlast = final byte of frame);
// a frame is a type byte, body bytes and a 4-byte little-endian crc trailer
// results leave on out_*: tuser 0 is a body byte, tuser 1 the frame status;
// tlast marks the last result caused by one input byte
// body bytes go out before the crc is known; drop them on a bad status
// one byte is accepted per cycle while in_tready is high; the byte-wide crc
// network sets this; a result is held in the queue, then in the output register;
// the final byte of a frame can cause two results, body then status; a 4-entry
// command queue between front and back end absorbs stalls; when it fills,
// in_tready drops until out_tready takes results again; reset clears frame state
// and sets type_limit to 256, serial_mode to 0; cfg_* writes type_limit at
// index 0 or serial_mode at index 1; user must write only while idle, unchecked
module crc32_frame_checker #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // data_byte
  input  logic         in_tlast,
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata,  // body_byte, status, frame_type, body_length,
                                   // crc_value, serial_number, zero fill
  output logic         out_tuser,  // kind
  output logic         out_tlast,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [8:0]   cfg_wdata
);

  logic [8:0]        type_limit_r;
  logic              serial_mode_r;
  logic              full;
  logic              take;
  logic              push;
  logic              pop;
  logic              head_valid;
  cfc_pkg::cfc_cmd_t push_cmd;
  cfc_pkg::cfc_cmd_t head_cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      type_limit_r <= 9'd256;
      serial_mode_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cfc_pkg::CFG_TYPE_LIMIT:  type_limit_r <= cfg_wdata;
        cfc_pkg::CFG_SERIAL_MODE: serial_mode_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign in_tready = !full;
  assign take = in_tvalid && !full;

  cfc_front #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take),
    .data_byte  (in_tdata),
    .last       (in_tlast),
    .type_limit (type_limit_r),
    .serial_mode(serial_mode_r),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  cfc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (full),
    .pop       (pop),
    .head_valid(head_valid),
    .head_cmd  (head_cmd)
  );

  cfc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_valid(head_valid),
    .head_cmd  (head_cmd),
    .pop       (pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

endmodule

// ----- bench/crc32_frame_checker_tb.sv -----
// crc32_frame_checker_tb: self-checking bench for the crc-32 trailer frame checker
// predicts body bytes and end-of-frame status per accepted byte and compares each
// output transfer in order; depends on cfc_pkg and crc32_frame_checker
module crc32_frame_checker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int   SETTLE_CYCLES   = 8;
  localparam int   RANDOM_BYTES    = 900;
  localparam int   CYCLE_LIMIT     = 1000000;

  typedef logic [7:0] byte_seq_t[$];

  typedef struct {
    logic        kind;
    logic [7:0]  body;
    logic [2:0]  status;
    logic [7:0]  ftype;
    logic [15:0] blen;
    logic [31:0] crc;
    logic [31:0] serial;
    logic        eor;
  } frame_out_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [7:0]   in_tdata;   // data_byte
  logic         in_tlast;
  logic         out_tvalid;
  logic         out_tready;
  logic [103:0] out_tdata;  // body_byte, status, frame_type, body_length,
                            // crc_value, serial_number, zero fill
  logic         out_tuser;  // kind
  logic         out_tlast;
  logic         cfg_we;
  logic         cfg_index;
  logic [8:0]   cfg_wdata;

  crc32_frame_checker uut (.*);

  // checker model state
  logic [7:0]  win_bytes[4];
  logic [31:0] crc_run;
  logic [15:0] byte_total;
  logic [7:0]  type_byte;
  logic [31:0] serial_acc;
  logic [8:0]  limit_model;
  logic        serial_model;

  frame_out_t  pending_outputs[$];

  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;
  int hold_len = 0;
  int mismatches = 0;
  int cycle_count = 0;
  int bytes_sent = 0;
  int frames_sent = 0;
  int results_checked = 0;
  int input_stalls = 0;
  int status_seen[5] = '{0, 0, 0, 0, 0};

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic logic [31:0] crc32_update(input logic [31:0] c, input logic [7:0] d);
    logic [31:0] r;
    r = c;
    for (int k = 0; k < 8; k++) begin
      if (r[0] ^ d[k]) r = (r >> 1) ^ cfc_pkg::CRC_POLY;
      else r = r >> 1;
    end
    return r;
  endfunction

  function automatic void clear_frame_state();
    for (int k = 0; k < 4; k++) win_bytes[k] = 8'h00;
    crc_run = cfc_pkg::CRC_INIT;
    byte_total = '0;
    type_byte = 8'h00;
    serial_acc = '0;
  endfunction

  function automatic frame_out_t make_out(input logic kind, input logic [7:0] body,
                                          input logic [2:0] status, input int blen,
                                          input logic [31:0] crc, input logic [31:0] serial,
                                          input logic eor);
    frame_out_t r;
    r.kind = kind;
    r.body = body;
    r.status = status;
    r.ftype = type_byte;
    r.blen = (blen > 65535) ? 16'hFFFF : 16'(blen);
    r.crc = crc;
    r.serial = serial;
    r.eor = eor;
    return r;
  endfunction

  // advance the frame model by one accepted byte and queue what it produces
  function automatic void track_frame_byte(input logic [7:0] b, input logic last);
    logic [7:0]  leaving;
    logic [31:0] crc_fin;
    logic [31:0] given;
    logic [2:0]  st;
    int pos, strip, len, body;
    strip = serial_model ? cfc_pkg::SERIAL_LEN : 0;
    if (byte_total == 0) type_byte = b;
    if (int'(byte_total) >= cfc_pkg::TRAILER_LEN) begin
      leaving = win_bytes[0];
      pos = int'(byte_total) - cfc_pkg::TRAILER_LEN;
      crc_run = crc32_update(crc_run, leaving);
      if (pos >= 1) begin
        if (serial_model && pos <= cfc_pkg::SERIAL_LEN) begin
          serial_acc |= 32'(leaving) << (8 * (pos - 1));
        end else begin
          pending_outputs.push_back(make_out(cfc_pkg::KIND_BODY, leaving, cfc_pkg::ST_OK,
                                             (pos > strip) ? pos - strip : 0, '0, '0,
                                             !last));
        end
      end
    end
    win_bytes[0] = win_bytes[1];
    win_bytes[1] = win_bytes[2];
    win_bytes[2] = win_bytes[3];
    win_bytes[3] = b;
    if (byte_total != 16'hFFFF) byte_total++;
    if (last) begin
      len = int'(byte_total);
      crc_fin = ~crc_run;
      given = {win_bytes[3], win_bytes[2], win_bytes[1], win_bytes[0]};
      body = (len >= cfc_pkg::MIN_FRAME) ? len - cfc_pkg::MIN_FRAME : 0;
      if (len < cfc_pkg::MIN_FRAME) st = cfc_pkg::ST_SHORT;
      else if ({1'b0, type_byte} >= limit_model) st = cfc_pkg::ST_BAD_TYPE;
      else if (crc_fin != given) st = cfc_pkg::ST_CRC_ERR;
      else if (serial_model && body < cfc_pkg::SERIAL_LEN) st = cfc_pkg::ST_NO_SERIAL;
      else st = cfc_pkg::ST_OK;
      status_seen[st]++;
      pending_outputs.push_back(make_out(cfc_pkg::KIND_STATUS, 8'h00, st,
                                         (body > strip) ? body - strip : 0,
                                         (len >= cfc_pkg::MIN_FRAME) ? crc_fin : '0,
                                         serial_model ? serial_acc : '0, 1'b1));
      clear_frame_state();
    end
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    frame_out_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_outputs.size() == 0) begin
        $error("unexpected result transfer: kind %0d data 0x%0h", out_tuser, out_tdata);
        mismatches++;
      end else begin
        e = pending_outputs.pop_front();
        results_checked++;
        check_field("kind", 32'(e.kind), 32'(out_tuser));
        check_field("body_byte", 32'(e.body), 32'(out_tdata[7:0]));
        check_field("status", 32'(e.status), 32'(out_tdata[10:8]));
        check_field("frame_type", 32'(e.ftype), 32'(out_tdata[18:11]));
        check_field("body_length", 32'(e.blen), 32'(out_tdata[34:19]));
        check_field("crc_value", e.crc, out_tdata[66:35]);
        check_field("serial_number", e.serial, out_tdata[98:67]);
        check_field("end_of_run", 32'(e.eor), 32'(out_tlast));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (rst_n && in_tvalid && !in_tready) input_stalls++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_outputs.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result side: random stalls per transfer, plus long hold-offs on request
  initial begin : result_sink
    int stall;
    int held;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_len > 0) begin
        out_tready <= 1'b0;
        held = 0;
        while (held < hold_len) begin
          @(posedge clk);
          held++;
        end
        hold_len = 0;
      end
      stall = rx_idle_on ? $urandom_range(0, 14) : 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready) && hold_len == 0);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= last;
    do @(posedge clk); while (!in_tready);
    track_frame_byte(b, last);
    bytes_sent++;
  endtask

  task automatic send_frame(input byte_seq_t s);
    foreach (s[i]) send_byte(s[i], i == s.size() - 1);
    frames_sent++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input logic idx, input logic [8:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    if (idx == cfc_pkg::CFG_TYPE_LIMIT) limit_model = val;
    else serial_model = val[0];
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic byte_seq_t with_fcs(input byte_seq_t s, input logic [31:0] flip);
    byte_seq_t r;
    logic [31:0] c;
    r = s;
    c = cfc_pkg::CRC_INIT;
    foreach (s[i]) c = crc32_update(c, s[i]);
    c = ~c ^ flip;
    for (int k = 0; k < 4; k++) r.push_back(c[8*k +: 8]);
    return r;
  endfunction

  function automatic byte_seq_t random_bytes(input int n);
    byte_seq_t r;
    for (int k = 0; k < n; k++) r.push_back(8'($urandom_range(0, 255)));
    return r;
  endfunction

  task automatic test_short_frames();
    send_frame('{8'h00});
    send_frame('{8'hFF, 8'h80, 8'h01, 8'h7F});
  endtask

  task automatic test_crc_check();
    send_frame(with_fcs('{8'h00}, 32'h0));
    send_frame(with_fcs('{8'hFF, 8'hFF, 8'h00}, 32'h8000_0000));
  endtask

  task automatic test_type_limit();
    drain();
    write_cfg(cfc_pkg::CFG_TYPE_LIMIT, 9'd0);
    send_frame(with_fcs('{8'h00}, 32'h0));
    drain();
    write_cfg(cfc_pkg::CFG_TYPE_LIMIT, 9'd511);
    send_frame(with_fcs('{8'hFF, 8'h55}, 32'h0));
    drain();
    write_cfg(cfc_pkg::CFG_TYPE_LIMIT, 9'd1);
    send_frame(with_fcs('{8'h01}, 32'h0));
    drain();
    write_cfg(cfc_pkg::CFG_TYPE_LIMIT, 9'd256);
  endtask

  task automatic test_serial_mode();
    drain();
    write_cfg(cfc_pkg::CFG_SERIAL_MODE, 9'd1);
    send_frame(with_fcs('{8'h10, 8'hAA, 8'hBB}, 32'h0));
    send_frame(with_fcs('{8'h11, 8'h01, 8'h02, 8'h03, 8'h04, 8'hC3}, 32'h0));
    send_frame(with_fcs('{8'h12}, 32'h1));
    drain();
    write_cfg(cfc_pkg::CFG_SERIAL_MODE, 9'd0);
  endtask

  task automatic test_serial_switch_mid_frame();
    byte_seq_t s;
    s = random_bytes(12);
    s.push_front(8'h03);
    s = with_fcs(s, 32'h0);
    for (int i = 0; i < 7; i++) send_byte(s[i], 1'b0);
    drain();
    write_cfg(cfc_pkg::CFG_SERIAL_MODE, 9'd1);
    for (int i = 7; i < s.size(); i++) send_byte(s[i], i == s.size() - 1);
    frames_sent++;
    drain();
    write_cfg(cfc_pkg::CFG_SERIAL_MODE, 9'd0);
  endtask

  task automatic test_backpressure();
    byte_seq_t s;
    drain();
    tx_idle_on = 1'b0;
    hold_len = 300;
    repeat (3) begin
      s = random_bytes(12);
      s.push_front(8'($urandom_range(0, 255)));
      send_frame(with_fcs(s, 32'h0));
    end
    drain();
    tx_idle_on = 1'b1;
  endtask

  task automatic random_frame();
    byte_seq_t s;
    int pick, blen, top;
    logic [7:0] t;
    logic [31:0] flip;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      s = random_bytes($urandom_range(1, 4));
    end else if (pick < 20) begin
      s = random_bytes($urandom_range(5, 24));
    end else begin
      top = (limit_model > 256) ? 256 : int'(limit_model);
      if (top > 0 && $urandom_range(0, 4) != 0) t = 8'($urandom_range(0, top - 1));
      else t = 8'($urandom_range(0, 255));
      blen = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(0, 12);
      s = random_bytes(blen);
      s.push_front(t);
      flip = '0;
      if (pick < 30) flip = 32'h1 << $urandom_range(0, 31);
      else if (pick < 35) flip = $urandom;
      s = with_fcs(s, flip);
    end
    send_frame(s);
  endtask

  task automatic test_random_traffic();
    int start;
    logic [8:0] lim;
    start = bytes_sent;
    while (bytes_sent - start < RANDOM_BYTES) begin
      drain();
      case ($urandom_range(0, 7))
        0: lim = 9'd0;
        1: lim = 9'd1;
        2: lim = 9'd511;
        3: lim = 9'($urandom_range(1, 256));
        default: lim = 9'd256;
      endcase
      write_cfg(cfc_pkg::CFG_TYPE_LIMIT, lim);
      write_cfg(cfc_pkg::CFG_SERIAL_MODE, 9'($urandom_range(0, 1)));
      tx_idle_on = $urandom_range(0, 3) != 0;
      rx_idle_on = $urandom_range(0, 3) != 0;
      repeat ($urandom_range(4, 12)) random_frame();
    end
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  initial begin
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= 8'h00;
    in_tlast <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= cfc_pkg::CFG_TYPE_LIMIT;
    cfg_wdata <= '0;
    limit_model = 9'd256;
    serial_model = 1'b0;
    clear_frame_state();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_short_frames();
    test_crc_check();
    test_type_limit();
    test_serial_mode();
    test_serial_switch_mid_frame();
    test_backpressure();
    test_random_traffic();
    drain();
    repeat (20) @(posedge clk);

    $display("covered %0d frames, %0d bytes, %0d result transfers, %0d input stall cycles",
             frames_sent, bytes_sent, results_checked, input_stalls);
    $display("status mix: ok %0d, short %0d, bad type %0d, crc error %0d, no serial %0d",
             status_seen[cfc_pkg::ST_OK], status_seen[cfc_pkg::ST_SHORT],
             status_seen[cfc_pkg::ST_BAD_TYPE], status_seen[cfc_pkg::ST_CRC_ERR],
             status_seen[cfc_pkg::ST_NO_SERIAL]);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
